// ----- rtl/cartesian_to_spherical_unit_defines.svh -----
`ifndef CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH

// same-cycle implication
`define C2S_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define C2S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- rtl/c2s_pkg.sv -----
`timescale 1ns / 1ps

package c2s_pkg;

	localparam int COORD_BITS        = 24;
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int GUARD_BITS        = 40 - COORD_BITS;
	localparam int RAD_W             = 2 * COORD_BITS;
	localparam int ROOT_W            = COORD_BITS + GUARD_BITS;
	localparam int SQRT_DIGITS       = ROOT_W;
	localparam int REM_W             = ROOT_W + 3;
	localparam int VEC_W             = ROOT_W + 3;
	localparam int ACC_W             = 34;
	localparam int FRAC_DROP         = 8;
	localparam int ROUND_BIAS        = 2 ** (FRAC_DROP - 1);
	localparam int RND_W             = ACC_W - FRAC_DROP;
	localparam int AZ_W              = COORD_BITS + 1;
	localparam int HALF_T24          = 2 ** 23;
	localparam int QUARTER_T24       = 2 ** 22;
	localparam int TAB_N             = 32;
	localparam int IN_TDATA_W        = ((3 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELDS_W      = 2 * COORD_BITS + AZ_W;
	localparam int OUT_TDATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W       = 2;

	localparam logic signed [ACC_W-1:0] QUARTER_T32 = ACC_W'(2 ** 30);

	// round(atan(2^-i) / (2*pi) * 2^32)
	localparam logic [31:0] ATAN_TAB [TAB_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   on_axis;
		logic   zero_r;
	} sq_side_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
		logic signed [ACC_W-1:0] acc;
	} vec_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] radius;
		logic                  x_neg;
		logic                  z_neg;
		logic                  on_axis;
		logic                  zero_r;
	} cr_side_t;

	// one digit of the restoring square root
	function automatic sqrt_t sqrt_step(sqrt_t s);
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		sqrt_t r;
		cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		r.rad = {s.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// one vectoring rotation
	function automatic vec_t cordic_step(vec_t v, logic [4:0] idx);
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
		logic signed [VEC_W-1:0] ash;
		logic signed [VEC_W-1:0] bsh;
		logic signed [ACC_W-1:0] ang;
		vec_t r;
		a   = v.a;
		b   = v.b;
		ash = a >>> idx;
		bsh = b >>> idx;
		ang = $signed({2'b00, ATAN_TAB[idx]});
		if (!b[VEC_W-1]) begin
			r.a   = a + bsh;
			r.b   = b - ash;
			r.acc = v.acc + ang;
		end else begin
			r.a   = a - bsh;
			r.b   = b + ash;
			r.acc = v.acc - ang;
		end
		return r;
	endfunction

	// quarter-turn fold into the right half plane
	function automatic vec_t prerotate(logic signed [VEC_W-1:0] a,
			logic signed [VEC_W-1:0] b);
		vec_t r;
		r.a   = a;
		r.b   = b;
		r.acc = '0;
		if (a[VEC_W-1]) begin
			if (!b[VEC_W-1]) begin
				r.a   = b;
				r.b   = -a;
				r.acc = QUARTER_T32;
			end else begin
				r.a   = -b;
				r.b   = a;
				r.acc = -QUARTER_T32;
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/c2s_sqrt_cell.sv -----
`timescale 1ns / 1ps

module c2s_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  c2s_pkg::sqrt_t     rsum_in,
	input  c2s_pkg::sqrt_t     rxy_in,
	input  c2s_pkg::sq_side_t  side_in,
	output logic               valid_out,
	output c2s_pkg::sqrt_t     rsum_out,
	output c2s_pkg::sqrt_t     rxy_out,
	output c2s_pkg::sq_side_t  side_out
);
	import c2s_pkg::*;
	`include "cartesian_to_spherical_unit_defines.svh"

	logic       valid_q;
	sqrt_t      rsum_q;
	sqrt_t      rxy_q;
	sq_side_t   side_q;
	logic [REM_W-1:0] xy_bound;
	logic [REM_W-1:0] sum_bound;
	logic             rem_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsum_q <= sqrt_step(rsum_in);
			rxy_q  <= sqrt_step(rxy_in);
			side_q <= side_in;
		end
	end

	assign valid_out = valid_q;
	assign rsum_out  = rsum_q;
	assign rxy_out   = rxy_q;
	assign side_out  = side_q;

	// partial remainder never exceeds twice the partial root
	assign xy_bound  = {2'b00, rxy_q.root, 1'b0};
	assign sum_bound = {2'b00, rsum_q.root, 1'b0};
	assign rem_ok    = (rxy_q.rem <= xy_bound) && (rsum_q.rem <= sum_bound);

	`C2S_ASSERT_NOW(a_rem_bound, valid_q, rem_ok, "sqrt remainder out of bound")

endmodule

// ----- rtl/c2s_cordic_cell.sv -----
`timescale 1ns / 1ps

module c2s_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  c2s_pkg::vec_t      pol_in,
	input  c2s_pkg::vec_t      az_in,
	input  c2s_pkg::cr_side_t  side_in,
	output logic               valid_out,
	output c2s_pkg::vec_t      pol_out,
	output c2s_pkg::vec_t      az_out,
	output c2s_pkg::cr_side_t  side_out
);
	import c2s_pkg::*;

	localparam logic [4:0] IDX = 5'(STAGE);

	logic      valid_q;
	vec_t      pol_q;
	vec_t      az_q;
	cr_side_t  side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pol_q  <= cordic_step(pol_in, IDX);
			az_q   <= cordic_step(az_in, IDX);
			side_q <= side_in;
		end
	end

	assign valid_out = valid_q;
	assign pol_out   = pol_q;
	assign az_out    = az_q;
	assign side_out  = side_q;

endmodule

// ----- rtl/cartesian_to_spherical_unit.sv -----
`timescale 1ns / 1ps

// Cartesian to spherical conversion, one point per request.
// s_axis carries a point: tdata holds x, y, z (24-bit signed each) from bit 0 up.
// m_axis returns radius, polar angle and azimuth in tdata, and the origin and
// z-axis flags in tuser. Angles are in units of 2^-24 turn.
// The pipeline has one squaring stage, one sum stage, a 40-cell square
// root chain, a fold stage, one CORDIC cell per stage and a rounding stage
// into the output register. Throughput is one point per cycle, back to back,
// while the pipeline advances.
// The pipeline advances as a whole; it halts only when the output register holds
// an untaken result and the last stage also holds one. Empty slots still drain,
// so the input keeps being taken while a result waits, until the bubbles run out.
// Reset clears all valid flags and the output valid; no result is pending after.

module cartesian_to_spherical_unit #(
	parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// x, y, z
	input  logic [c2s_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// radius, polar_angle, azimuth, zero padding
	output logic [c2s_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// zero_radius, on_axis
	output logic [c2s_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
	import c2s_pkg::*;
	`include "cartesian_to_spherical_unit_defines.svh"

	localparam logic signed [RND_W:0] HALF_R      = (RND_W + 1)'(HALF_T24);
	localparam logic signed [RND_W:0] QUARTER_R   = (RND_W + 1)'(QUARTER_T24);
	localparam logic signed [RND_W:0] THREE_Q_M1  = (RND_W + 1)'(3 * QUARTER_T24 - 1);

	logic adv;

	coord_t x_in;
	coord_t y_in;
	coord_t z_in;

	// stage 1: squares
	logic                    v_s1;
	logic [RAD_W-1:0]        xx_s1;
	logic [RAD_W-1:0]        yy_s1;
	logic [RAD_W-1:0]        zz_s1;
	sq_side_t                side_s1;
	logic signed [RAD_W-1:0] xx_p;
	logic signed [RAD_W-1:0] yy_p;
	logic signed [RAD_W-1:0] zz_p;

	// stage 2: sums
	logic             v_s2;
	logic [RAD_W-1:0] sum_s2;
	logic [RAD_W-1:0] sxy_s2;
	sq_side_t         side_s2;

	// square root chain
	logic     sq_v    [SQRT_DIGITS+1];
	sqrt_t    rsum_w  [SQRT_DIGITS+1];
	sqrt_t    rxy_w   [SQRT_DIGITS+1];
	sq_side_t sqs_w   [SQRT_DIGITS+1];

	// stage 3: vector setup
	logic                    v_s3;
	vec_t                    pol_s3;
	vec_t                    az_s3;
	cr_side_t                side_s3;
	sq_side_t                sq_end;
	logic [COORD_BITS:0]     xabs;
	logic signed [VEC_W-1:0] pol_a;
	logic signed [VEC_W-1:0] pol_b;

	// cordic chain
	logic     cr_v    [CORDIC_STAGES+1];
	vec_t     pol_w   [CORDIC_STAGES+1];
	vec_t     az_w    [CORDIC_STAGES+1];
	cr_side_t crs_w   [CORDIC_STAGES+1];

	// stage 4: rounding
	logic                    v_s4;
	logic signed [RND_W-1:0] pr_s4;
	logic signed [RND_W-1:0] ar_s4;
	cr_side_t                side_s4;
	logic signed [ACC_W-1:0] pacc;
	logic signed [ACC_W-1:0] aacc;

	// output register
	logic                    m_valid_q;
	logic [COORD_BITS-1:0]   radius_q;
	logic [COORD_BITS-1:0]   polar_q;
	logic [AZ_W-1:0]         azim_q;
	logic                    zero_q;
	logic                    axis_q;
	logic signed [RND_W-1:0] pol_n;
	logic signed [RND_W:0]   az_n;
	logic signed [RND_W:0]   az_mirror;
	logic signed [RND_W:0]   az_direct;
	logic                    origin_ok;
	logic                    polar_ok;

	assign adv           = !v_s4 || !m_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	assign x_in = s_axis_tdata[COORD_BITS-1:0];
	assign y_in = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign z_in = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

	assign xx_p = x_in * x_in;
	assign yy_p = y_in * y_in;
	assign zz_p = z_in * z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= sq_v[SQRT_DIGITS];
			v_s4 <= cr_v[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s1           <= xx_p;
			yy_s1           <= yy_p;
			zz_s1           <= zz_p;
			side_s1.x       <= x_in;
			side_s1.y       <= y_in;
			side_s1.z       <= z_in;
			side_s1.on_axis <= (x_in == '0) && (y_in == '0);
			side_s1.zero_r  <= (x_in == '0) && (y_in == '0) && (z_in == '0);

			sum_s2  <= xx_s1 + yy_s1 + zz_s1;
			sxy_s2  <= xx_s1 + yy_s1;
			side_s2 <= side_s1;
		end
	end

	assign sq_v[0]        = v_s2;
	assign rsum_w[0].rad  = sum_s2;
	assign rsum_w[0].rem  = '0;
	assign rsum_w[0].root = '0;
	assign rxy_w[0].rad   = sxy_s2;
	assign rxy_w[0].rem   = '0;
	assign rxy_w[0].root  = '0;
	assign sqs_w[0]       = side_s2;

	for (genvar k = 0; k < SQRT_DIGITS; k++) begin : g_sqrt
		c2s_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.valid_in  (sq_v[k]),
			.rsum_in   (rsum_w[k]),
			.rxy_in    (rxy_w[k]),
			.side_in   (sqs_w[k]),
			.valid_out (sq_v[k+1]),
			.rsum_out  (rsum_w[k+1]),
			.rxy_out   (rxy_w[k+1]),
			.side_out  (sqs_w[k+1])
		);
	end

	assign sq_end = sqs_w[SQRT_DIGITS];
	assign xabs   = sq_end.x[COORD_BITS-1] ? -((COORD_BITS + 1)'(sq_end.x))
		: (COORD_BITS + 1)'(sq_end.x);
	assign pol_a  = {{(VEC_W - COORD_BITS - GUARD_BITS){sq_end.z[COORD_BITS-1]}},
		sq_end.z, {GUARD_BITS{1'b0}}};
	assign pol_b  = {{(VEC_W - ROOT_W){1'b0}}, rxy_w[SQRT_DIGITS].root};

	always_ff @(posedge clk) begin
		if (adv) begin
			pol_s3         <= prerotate(pol_a, pol_b);
			az_s3.a        <= {{(VEC_W - COORD_BITS - 1 - GUARD_BITS){1'b0}}, xabs,
				{GUARD_BITS{1'b0}}};
			az_s3.b        <= {{(VEC_W - COORD_BITS - GUARD_BITS){sq_end.y[COORD_BITS-1]}},
				sq_end.y, {GUARD_BITS{1'b0}}};
			az_s3.acc      <= '0;
			side_s3.radius <= rsum_w[SQRT_DIGITS].root[GUARD_BITS +: COORD_BITS];
			side_s3.x_neg  <= sq_end.x[COORD_BITS-1];
			side_s3.z_neg  <= sq_end.z[COORD_BITS-1];
			side_s3.on_axis <= sq_end.on_axis;
			side_s3.zero_r <= sq_end.zero_r;
		end
	end

	assign cr_v[0]  = v_s3;
	assign pol_w[0] = pol_s3;
	assign az_w[0]  = az_s3;
	assign crs_w[0] = side_s3;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		c2s_cordic_cell #(
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.valid_in  (cr_v[i]),
			.pol_in    (pol_w[i]),
			.az_in     (az_w[i]),
			.side_in   (crs_w[i]),
			.valid_out (cr_v[i+1]),
			.pol_out   (pol_w[i+1]),
			.az_out    (az_w[i+1]),
			.side_out  (crs_w[i+1])
		);
	end

	assign pacc = pol_w[CORDIC_STAGES].acc + ACC_W'(ROUND_BIAS);
	assign aacc = az_w[CORDIC_STAGES].acc + ACC_W'(ROUND_BIAS);

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s4   <= RND_W'(pacc >>> FRAC_DROP);
			ar_s4   <= RND_W'(aacc >>> FRAC_DROP);
			side_s4 <= crs_w[CORDIC_STAGES];
		end
	end

	always_comb begin
		az_mirror = HALF_R - (RND_W + 1)'(ar_s4);
		az_direct = (RND_W + 1)'(ar_s4);
		if (side_s4.on_axis) begin
			pol_n = side_s4.z_neg ? RND_W'(HALF_T24) : '0;
			az_n  = '0;
		end else begin
			if (pr_s4[RND_W-1]) begin
				pol_n = '0;
			end else if (pr_s4 > RND_W'(HALF_T24)) begin
				pol_n = RND_W'(HALF_T24);
			end else begin
				pol_n = pr_s4;
			end
			if (side_s4.x_neg) begin
				if (az_mirror < QUARTER_R) begin
					az_n = QUARTER_R;
				end else if (az_mirror > THREE_Q_M1) begin
					az_n = THREE_Q_M1;
				end else begin
					az_n = az_mirror;
				end
			end else begin
				if (az_direct < -QUARTER_R) begin
					az_n = -QUARTER_R;
				end else if (az_direct > QUARTER_R) begin
					az_n = QUARTER_R;
				end else begin
					az_n = az_direct;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (v_s4 && adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && adv) begin
			radius_q <= side_s4.radius;
			polar_q  <= COORD_BITS'(pol_n);
			azim_q   <= AZ_W'(az_n);
			zero_q   <= side_s4.zero_r;
			axis_q   <= side_s4.on_axis;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, azim_q, polar_q, radius_q};
	assign m_axis_tuser  = {axis_q, zero_q};

	assign origin_ok = axis_q && (radius_q == '0) && (polar_q == '0) && (azim_q == '0);
	assign polar_ok  = polar_q <= COORD_BITS'(HALF_T24);

	`C2S_ASSERT_NOW(a_origin_result, m_valid_q && zero_q, origin_ok, "origin result not all zero")
	`C2S_ASSERT_NOW(a_axis_azimuth, m_valid_q && axis_q, azim_q == '0, "azimuth not zero on z axis")
	`C2S_ASSERT_NOW(a_polar_range, m_valid_q, polar_ok, "polar angle beyond half turn")
	`C2S_ASSERT_NEXT(a_result_lands, v_s4 && adv, m_valid_q, "finished point did not reach output")

endmodule

// ----- test/cartesian_to_spherical_unit_tb.sv -----
`timescale 1ns / 1ps

module cartesian_to_spherical_unit_tb;
	import c2s_pkg::*;

	localparam int STAGES      = CORDIC_STAGES_DEF;
	localparam int LATENCY     = 45 + STAGES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam longint QUARTER_TURN_ACC = 64'sd1 << 30;
	localparam coord_t C_MAX = coord_t'(24'h7fffff);
	localparam coord_t C_MIN = coord_t'(24'h800000);

	localparam longint ARCTAN_TURNS [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	typedef struct {
		logic [COORD_BITS-1:0]      radius;
		logic [COORD_BITS-1:0]      polar;
		logic signed [AZ_W-1:0]     azimuth;
		logic                       zero_r;
		logic                       on_axis;
	} spherical_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [IN_TDATA_W-1:0]       s_axis_tdata = '0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]      m_axis_tdata;
	logic [OUT_TUSER_W-1:0]      m_axis_tuser;

	spherical_t expected_spherical [$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;
	int  hold_count = 0;
	int  hold_seen = 0;
	int  hold_left = 0;

	cartesian_to_spherical_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// floor(sqrt(v) * 2^frac), one digit per pass
	function automatic longint unsigned root_floor(longint unsigned v, int frac);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned trial;
		longint unsigned bits;
		rem  = 0;
		root = 0;
		for (int k = 31; k >= -frac; k--) begin
			bits  = (k >= 0) ? ((v >> (2 * k)) & 64'd3) : 64'd0;
			rem   = (rem << 2) | bits;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// atan2(b, a) in 2^-24 turn
	function automatic longint vector_angle(longint a_in, longint b_in);
		longint a;
		longint b;
		longint acc;
		longint na;
		longint nb;
		longint t;
		a   = a_in;
		b   = b_in;
		acc = 0;
		if (a < 0) begin
			if (b >= 0) begin
				t   = a;
				a   = b;
				b   = -t;
				acc = QUARTER_TURN_ACC;
			end else begin
				t   = a;
				a   = -b;
				b   = t;
				acc = -QUARTER_TURN_ACC;
			end
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			if (b >= 0) begin
				na  = a + (b >>> i);
				nb  = b - (a >>> i);
				acc = acc + ARCTAN_TURNS[i];
			end else begin
				na  = a - (b >>> i);
				nb  = b + (a >>> i);
				acc = acc - ARCTAN_TURNS[i];
			end
			a = na;
			b = nb;
		end
		return (acc + 128) >>> 8;
	endfunction

	function automatic longint clamp_angle(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic spherical_t to_spherical(coord_t x, coord_t y, coord_t z);
		longint xl;
		longint yl;
		longint zl;
		longint sxy;
		longint sf;
		longint polar;
		longint azim;
		longint sc;
		spherical_t r;
		xl    = longint'(x);
		yl    = longint'(y);
		zl    = longint'(z);
		sc    = 64'sd1 << GUARD_BITS;
		sxy   = xl * xl + yl * yl;
		polar = 0;
		azim  = 0;
		r.radius  = COORD_BITS'(root_floor(longint'(sxy + zl * zl), 0));
		r.on_axis = (xl == 0 && yl == 0);
		r.zero_r  = r.on_axis && zl == 0;
		if (r.on_axis) begin
			polar = (zl < 0) ? HALF_T24 : 0;
		end else begin
			sf    = longint'(root_floor(sxy, GUARD_BITS));
			polar = clamp_angle(vector_angle(zl * sc, sf), 0, HALF_T24);
			if (xl >= 0)
				azim = clamp_angle(vector_angle(xl * sc, yl * sc), -QUARTER_T24, QUARTER_T24);
			else
				azim = clamp_angle(HALF_T24 - vector_angle(-xl * sc, yl * sc),
						QUARTER_T24, 3 * QUARTER_T24 - 1);
		end
		r.polar   = polar[COORD_BITS-1:0];
		r.azimuth = azim[AZ_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		mismatches++;
	endtask

	// one request, held until the block takes it
	task automatic send_point(coord_t x, coord_t y, coord_t z);
		while (idle_on && $urandom_range(0, 99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z, y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_spherical.push_back(to_spherical(x, y, z));
	endtask

	function automatic coord_t pick_coord();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel) inside
			[0:4]:   return coord_t'($urandom);
			[5:6]:   return coord_t'(int'($urandom_range(0, 128)) - 64);
			7:       return '0;
			8:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
			default: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	task automatic send_random_point();
		coord_t x;
		coord_t y;
		x = pick_coord();
		y = pick_coord();
		if ($urandom_range(0, 99) < 8) begin
			x = '0;
			y = '0;
		end
		send_point(x, y, pick_coord());
	endtask

	task automatic test_directed();
		send_point('0, '0, '0);
		send_point('0, '0, coord_t'(1));
		send_point('0, '0, coord_t'(-1));
		send_point('0, '0, C_MAX);
		send_point('0, '0, C_MIN);
		send_point(C_MAX, C_MAX, C_MAX);
		send_point(C_MIN, C_MIN, C_MIN);
		send_point(C_MAX, C_MIN, C_MAX);
		send_point(C_MIN, C_MAX, C_MIN);
		send_point(C_MAX, '0, '0);
		send_point(C_MIN, '0, '0);
		send_point('0, C_MAX, '0);
		send_point('0, C_MIN, '0);
		send_point(coord_t'(1), '0, '0);
		send_point(coord_t'(-1), '0, '0);
		send_point('0, coord_t'(1), '0);
		send_point('0, coord_t'(-1), '0);
		send_point(coord_t'(-1), C_MAX, '0);
		send_point(coord_t'(-1), C_MIN, '0);
		send_point(coord_t'(1), C_MIN, C_MIN);
		send_point(coord_t'(-1), coord_t'(-1), coord_t'(1));
		send_point(coord_t'(1), coord_t'(1), C_MAX);
		send_point(coord_t'(-3), coord_t'(4), coord_t'(-12));
	endtask

	task automatic test_random_idling();
		idle_on = 1'b1;
		repeat (900)
			send_random_point();
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (200)
			send_random_point();
		idle_on = 1'b1;
	endtask

	// receiver holds off while requests keep coming, so the pipeline fills
	task automatic test_output_hold();
		idle_on = 1'b0;
		hold_count <= hold_count + 1;
		repeat (200)
			send_random_point();
		idle_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_count) begin
			hold_seen     <= hold_count;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on) begin
			m_axis_tready <= ($urandom_range(0, 99) >= 33);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		spherical_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_spherical.size() == 0) begin
				report_mismatch("unexpected result, radius", m_axis_tdata[23:0], 0);
			end else begin
				want = expected_spherical.pop_front();
				if (m_axis_tdata[23:0] !== want.radius)
					report_mismatch("radius", m_axis_tdata[23:0], want.radius);
				if (m_axis_tdata[47:24] !== want.polar)
					report_mismatch("polar_angle", m_axis_tdata[47:24], want.polar);
				if (m_axis_tdata[72:48] !== want.azimuth)
					report_mismatch("azimuth", $signed(m_axis_tdata[72:48]), want.azimuth);
				if (m_axis_tuser[0] !== want.zero_r)
					report_mismatch("zero_radius", m_axis_tuser[0], want.zero_r);
				if (m_axis_tuser[1] !== want.on_axis)
					report_mismatch("on_axis", m_axis_tuser[1], want.on_axis);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cartesian_to_spherical_unit test failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_idling();
		test_back_to_back();
		test_output_hold();
		s_axis_tvalid <= 1'b0;
		while (expected_spherical.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 32) @(posedge clk);
		if (mismatches == 0 && expected_spherical.size() == 0)
			$display("cartesian_to_spherical_unit test passed");
		else
			$display("cartesian_to_spherical_unit test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/c2s_pkg.sv
rtl/c2s_sqrt_cell.sv
rtl/c2s_cordic_cell.sv
rtl/cartesian_to_spherical_unit.sv
test/cartesian_to_spherical_unit_tb.sv
